### rtl/key_hold_counter_with_repeat_assert.svh
// Assertion macros shared by the key hold counter modules.
`ifndef KEY_HOLD_COUNTER_WITH_REPEAT_ASSERT_SVH
`define KEY_HOLD_COUNTER_WITH_REPEAT_ASSERT_SVH

// Antecedent holds in this cycle, consequent holds in the same cycle.
`define KHCR_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent holds in this cycle, consequent holds in the next cycle.
`define KHCR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/khcr_pkg.sv
// Package with constants, types and command structs of the key hold counter.
package khcr_pkg;

  localparam int KEY_COUNT   = 256;
  localparam int COUNT_WIDTH = 16;

  localparam int KEY_W      = 8;
  localparam int KEY_IDX_W  = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
  localparam int CNT_W      = COUNT_WIDTH;
  localparam int FRAMES_W   = 16;
  localparam int CFG_W      = 16;
  localparam int TOT_W      = 9;
  localparam int DIV_W      = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam int DIV_RADIX  = 4;
  localparam int DIV_STEPS  = (DIV_W + DIV_RADIX - 1) / DIV_RADIX;
  localparam int DIV_X_W    = DIV_STEPS * DIV_RADIX;
  localparam int STEP_W     = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

  localparam logic [CFG_W-1:0] FIRST_DELAY_RST   = 16'd17;
  localparam logic [CFG_W-1:0] REPEAT_PERIOD_RST = 16'd4;

  typedef enum logic {
    CFG_FIRST_DELAY   = 1'b0,
    CFG_REPEAT_PERIOD = 1'b1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_UPD,
    S_DIV,
    S_DONE
  } state_t;

  typedef struct packed {
    logic accept;
    logic update;
    logic div_step;
    logic load_out;
  } khcr_cmd_t;

  typedef struct packed {
    logic need_div;
    logic out_free;
  } khcr_sts_t;

endpackage

### rtl/khcr_ctrl.sv
// Controller state machine that sequences update, remainder steps and output load.
module khcr_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  khcr_pkg::khcr_sts_t sts,
  output khcr_pkg::khcr_cmd_t cmd
);
  import khcr_pkg::*;

  state_t            state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    step_nxt     = step_r;
    cmd          = '0;
    in_stall     = 1'b1;
    case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_UPD;
        end
      end
      S_UPD: begin
        cmd.update = 1'b1;
        step_nxt   = '0;
        state_nxt  = sts.need_div ? S_DIV : S_DONE;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (step_r == STEP_W'(DIV_STEPS - 1)) begin
          state_nxt = S_DONE;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  `include "key_hold_counter_with_repeat_assert.svh"

  `KHCR_ASSERT_NEXT(a_accept_then_busy, cmd.accept, in_stall, "accept not followed by busy")
  `KHCR_ASSERT_NEXT(a_div_bounded, (state_r == S_DIV) && (step_r == STEP_W'(DIV_STEPS - 1)), (state_r == S_DONE), "remainder steps overran")

endmodule

### rtl/khcr_dp.sv
// Datapath with hold count memory, running totals, remainder unit and result register.
module khcr_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  khcr_pkg::khcr_cmd_t          cmd,
  output khcr_pkg::khcr_sts_t          sts,
  input  logic [khcr_pkg::KEY_W-1:0]   in_key,
  input  logic                         in_pressed,
  input  logic                         in_focus_active,
  input  logic                         cfg_we,
  input  logic                         cfg_addr,
  input  logic [khcr_pkg::CFG_W-1:0]   cfg_wdata,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [khcr_pkg::KEY_W-1:0]   out_key_echo,
  output logic                         out_held,
  output logic                         out_just_pressed,
  output logic [khcr_pkg::FRAMES_W-1:0] out_hold_frames,
  output logic                         out_repeat_hit,
  output logic                         out_any_held,
  output logic                         out_any_just_pressed
);
  import khcr_pkg::*;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  logic [CNT_W-1:0]     mem [KEY_COUNT];
  logic [KEY_COUNT-1:0] vld_r;
  logic [CNT_W-1:0]     rd_data_r;

  logic [KEY_W-1:0]     key_r;
  logic                 down_r;
  logic                 focus_r;
  logic [CFG_W-1:0]     first_delay_r;
  logic [CFG_W-1:0]     period_r;
  logic [TOT_W-1:0]     held_tot_r, held_tot_nxt;
  logic [TOT_W-1:0]     just_tot_r, just_tot_nxt;
  logic [CNT_W-1:0]     c_r;
  logic                 res_ok_r;
  logic                 one_r;
  logic                 div_used_r;
  logic [DIV_X_W-1:0]   x_r, x_nxt;
  logic [DIV_W-1:0]     rem_r, rem_nxt;

  logic                 out_valid_r;
  logic [KEY_W-1:0]     out_key_r;
  logic                 out_held_r;
  logic                 out_just_r;
  logic [FRAMES_W-1:0]  out_frames_r;
  logic                 out_hit_r;
  logic                 out_any_held_r;
  logic                 out_any_just_r;

  logic [KEY_IDX_W-1:0] key_idx;
  logic [KEY_IDX_W-1:0] in_idx;
  logic                 in_range;
  logic                 upd_ok;
  logic [CNT_W-1:0]     old_c;
  logic [CNT_W-1:0]     c_nxt;
  logic [DIV_W-1:0]     c_wide;
  logic [DIV_W-1:0]     fd_wide;
  logic [DIV_W-1:0]     d_wide;
  logic                 gt_delay;
  logic                 hit_now;

  assign key_idx  = key_r[KEY_IDX_W-1:0];
  assign in_idx   = in_key[KEY_IDX_W-1:0];
  assign in_range = ({1'b0, key_r} < (KEY_W + 1)'(KEY_COUNT));
  assign upd_ok   = focus_r && in_range;
  assign old_c    = vld_r[key_idx] ? rd_data_r : '0;
  assign c_nxt    = !down_r ? '0 : ((old_c == CNT_MAX) ? CNT_MAX : old_c + 1'b1);
  assign c_wide   = DIV_W'(c_nxt);
  assign fd_wide  = DIV_W'(first_delay_r);
  assign d_wide   = DIV_W'(period_r);
  assign gt_delay = (c_wide > fd_wide);

  assign sts.need_div = upd_ok && gt_delay;
  assign sts.out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (cmd.update && upd_ok) begin
      mem[key_idx] <= c_nxt;
    end
    if (cmd.accept) begin
      rd_data_r <= mem[in_idx];
    end
  end

  always_comb begin
    held_tot_nxt = held_tot_r + TOT_W'(c_nxt != '0) - TOT_W'(old_c != '0);
    just_tot_nxt = just_tot_r + TOT_W'(c_nxt == CNT_W'(1)) - TOT_W'(old_c == CNT_W'(1));
  end

  always_comb begin
    logic [DIV_W:0]     t;
    logic [DIV_W-1:0]   r;
    logic [DIV_X_W-1:0] x;
    r = rem_r;
    x = x_r;
    for (int i = 0; i < DIV_RADIX; i++) begin
      t = {r, x[DIV_X_W-1]};
      x = {x[DIV_X_W-2:0], 1'b0};
      if (t >= {1'b0, d_wide}) begin
        t = t - {1'b0, d_wide};
      end
      r = t[DIV_W-1:0];
    end
    rem_nxt = r;
    x_nxt   = x;
  end

  assign hit_now = div_used_r ? ((rem_r == DIV_W'(1)) && (period_r != '0)) : one_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r         <= '0;
      held_tot_r    <= '0;
      just_tot_r    <= '0;
      first_delay_r <= FIRST_DELAY_RST;
      period_r      <= REPEAT_PERIOD_RST;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          CFG_FIRST_DELAY:   first_delay_r <= cfg_wdata;
          CFG_REPEAT_PERIOD: period_r      <= cfg_wdata;
          default:           first_delay_r <= first_delay_r;
        endcase
      end
      if (cmd.accept && !in_focus_active) begin
        vld_r      <= '0;
        held_tot_r <= '0;
        just_tot_r <= '0;
      end else if (cmd.update && upd_ok) begin
        vld_r[key_idx] <= 1'b1;
        held_tot_r     <= held_tot_nxt;
        just_tot_r     <= just_tot_nxt;
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      key_r   <= in_key;
      down_r  <= in_pressed;
      focus_r <= in_focus_active;
    end
    if (cmd.update) begin
      c_r        <= upd_ok ? c_nxt : '0;
      res_ok_r   <= upd_ok;
      one_r      <= upd_ok && (c_nxt == CNT_W'(1));
      div_used_r <= upd_ok && gt_delay;
      x_r        <= DIV_X_W'(c_wide - fd_wide);
      rem_r      <= '0;
    end else if (cmd.div_step) begin
      x_r   <= x_nxt;
      rem_r <= rem_nxt;
    end
    if (cmd.load_out) begin
      out_key_r      <= key_r;
      out_held_r     <= res_ok_r && (c_r != '0);
      out_just_r     <= res_ok_r && (c_r == CNT_W'(1));
      out_frames_r   <= res_ok_r ? FRAMES_W'(c_r) : '0;
      out_hit_r      <= res_ok_r && hit_now;
      out_any_held_r <= (held_tot_r != '0);
      out_any_just_r <= (just_tot_r != '0);
    end
  end

  assign out_valid            = out_valid_r;
  assign out_key_echo         = out_key_r;
  assign out_held             = out_held_r;
  assign out_just_pressed     = out_just_r;
  assign out_hold_frames      = out_frames_r;
  assign out_repeat_hit       = out_hit_r;
  assign out_any_held         = out_any_held_r;
  assign out_any_just_pressed = out_any_just_r;

  `include "key_hold_counter_with_repeat_assert.svh"

  `KHCR_ASSERT_SAME(a_held_tot_range, 1'b1, (held_tot_r <= TOT_W'(KEY_COUNT)), "held total exceeds key count")
  `KHCR_ASSERT_SAME(a_just_le_held, 1'b1, (just_tot_r <= held_tot_r), "just-pressed total exceeds held total")
  `KHCR_ASSERT_SAME(a_just_implies_held, out_valid_r && out_just_r, out_held_r && out_any_held_r && out_any_just_r, "just pressed result without held flags")
  `KHCR_ASSERT_NEXT(a_rem_below_period, cmd.div_step && (period_r != '0), (rem_r < d_wide), "remainder not below period")

endmodule

### rtl/key_hold_counter_with_repeat.sv
// A result is registered after its beat is accepted and updated, first passing through the
// repeat remainder unit, which runs 4 steps of 4 bits, when the count is past the first delay.
// A new beat is accepted only after the previous result is loaded, which waits on output stalls.
// The single-port hold count memory and the remainder unit serve one key at a time.
// Reset clears all hold counts at once through per-key valid bits, zeroes both totals and
// loads first_delay with 17 and repeat_period with 4; no clearing pass is needed.
module key_hold_counter_with_repeat (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [khcr_pkg::KEY_W-1:0]    in_key,
  input  logic                          in_pressed,
  input  logic                          in_focus_active,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [khcr_pkg::KEY_W-1:0]    out_key_echo,
  output logic                          out_held,
  output logic                          out_just_pressed,
  output logic [khcr_pkg::FRAMES_W-1:0] out_hold_frames,
  output logic                          out_repeat_hit,
  output logic                          out_any_held,
  output logic                          out_any_just_pressed,
  input  logic                          cfg_we,
  input  logic                          cfg_addr,
  input  logic [khcr_pkg::CFG_W-1:0]    cfg_wdata
);
  import khcr_pkg::*;

  khcr_cmd_t cmd;
  khcr_sts_t sts;

  khcr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  khcr_dp u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .sts                  (sts),
    .in_key               (in_key),
    .in_pressed           (in_pressed),
    .in_focus_active      (in_focus_active),
    .cfg_we               (cfg_we),
    .cfg_addr             (cfg_addr),
    .cfg_wdata            (cfg_wdata),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_key_echo         (out_key_echo),
    .out_held             (out_held),
    .out_just_pressed     (out_just_pressed),
    .out_hold_frames      (out_hold_frames),
    .out_repeat_hit       (out_repeat_hit),
    .out_any_held         (out_any_held),
    .out_any_just_pressed (out_any_just_pressed)
  );

endmodule

### verif/key_hold_counter_with_repeat_tb.sv
// Self-checking testbench for the key hold counter with typematic repeat.
module key_hold_counter_with_repeat_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import khcr_pkg::*;

  localparam int IDLE_LIMIT = 2000;
  localparam int PRINT_CAP  = 40;

  typedef struct packed {
    logic [KEY_W-1:0]    key_echo;
    logic                held;
    logic                just_pressed;
    logic [FRAMES_W-1:0] hold_frames;
    logic                repeat_hit;
    logic                any_held;
    logic                any_just_pressed;
  } key_report_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [KEY_W-1:0]    in_key = '0;
  logic                in_pressed = 1'b0;
  logic                in_focus_active = 1'b0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [KEY_W-1:0]    out_key_echo;
  logic                out_held;
  logic                out_just_pressed;
  logic [FRAMES_W-1:0] out_hold_frames;
  logic                out_repeat_hit;
  logic                out_any_held;
  logic                out_any_just_pressed;
  logic                cfg_we = 1'b0;
  logic                cfg_addr = 1'b0;
  logic [CFG_W-1:0]    cfg_wdata = '0;

  logic [CNT_W-1:0] hold_cnt [KEY_COUNT];
  logic [TOT_W-1:0] keys_held;
  logic [TOT_W-1:0] keys_just;
  logic [CFG_W-1:0] delay_reg;
  logic [CFG_W-1:0] period_reg;

  key_report_t expected_reports [$];
  int          mismatches = 0;
  bit          gaps_on = 1'b1;
  bit          stall_on = 1'b1;

  key_hold_counter_with_repeat dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic typematic_hit(logic [CNT_W-1:0] c);
    logic [CNT_W-1:0] r;
    r = c;
    if (c > delay_reg) begin
      if (period_reg == '0) return 1'b0;
      r = (c - delay_reg) % period_reg;
    end
    return r == 1;
  endfunction

  function automatic key_report_t predict_frame(logic [KEY_W-1:0] key, logic pressed,
                                                logic focus);
    key_report_t      r;
    logic [CNT_W-1:0] old_c;
    logic [CNT_W-1:0] c;
    r = '0;
    r.key_echo = key;
    if (!focus) begin
      foreach (hold_cnt[i]) hold_cnt[i] = '0;
      keys_held = '0;
      keys_just = '0;
      return r;
    end
    old_c = hold_cnt[key];
    if (!pressed) c = '0;
    else if (old_c == '1) c = old_c;
    else c = old_c + 1'b1;
    hold_cnt[key] = c;
    if (old_c != 0) keys_held--;
    if (old_c == 1) keys_just--;
    if (c != 0) keys_held++;
    if (c == 1) keys_just++;
    r.held = c != 0;
    r.just_pressed = c == 1;
    r.hold_frames = c[FRAMES_W-1:0];
    r.repeat_hit = typematic_hit(c);
    r.any_held = keys_held != 0;
    r.any_just_pressed = keys_just != 0;
    return r;
  endfunction

  function automatic int gap_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
  endfunction

  task automatic report_mismatch(string msg);
    mismatches++;
    if (mismatches <= PRINT_CAP) $display("MISMATCH: %s", msg);
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want,
                             logic [KEY_W-1:0] key);
    if (got !== want)
      report_mismatch($sformatf("key %0d %s got %0h expected %0h", key, name, got, want));
  endtask

  task automatic send_frame(logic [KEY_W-1:0] key, logic pressed, logic focus);
    int   gap;
    logic go;
    gap = (gaps_on && $urandom_range(0, 3) == 0) ? gap_len() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_key <= key;
    in_pressed <= pressed;
    in_focus_active <= focus;
    do begin
      @(negedge clk);
      go = !in_stall;
      @(posedge clk);
    end while (!go);
    expected_reports.push_back(predict_frame(key, pressed, focus));
  endtask

  task automatic go_idle();
    in_valid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CFG_W-1:0] value);
    go_idle();
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_FIRST_DELAY) delay_reg = value;
    else period_reg = value;
  endtask

  task automatic test_reset_defaults();
    send_frame(8'd0, 1'b1, 1'b1);
    send_frame(8'd255, 1'b1, 1'b1);
    send_frame(8'd0, 1'b1, 1'b1);
    send_frame(8'd0, 1'b0, 1'b1);
    send_frame(8'd255, 1'b0, 1'b1);
    send_frame(8'd128, 1'b0, 1'b1);
  endtask

  task automatic test_typematic();
    write_reg(CFG_FIRST_DELAY, 16'd2);
    write_reg(CFG_REPEAT_PERIOD, 16'd3);
    // Key 8 keeps its count of one while key 7 is sampled.
    send_frame(8'd8, 1'b1, 1'b1);
    repeat (8) send_frame(8'd7, 1'b1, 1'b1);
    send_frame(8'd8, 1'b0, 1'b1);
    send_frame(8'd7, 1'b0, 1'b1);
  endtask

  task automatic test_zero_period();
    write_reg(CFG_REPEAT_PERIOD, 16'd0);
    repeat (5) send_frame(8'd9, 1'b1, 1'b1);
    send_frame(8'd9, 1'b0, 1'b1);
  endtask

  task automatic test_focus_loss();
    send_frame(8'd3, 1'b1, 1'b1);
    send_frame(8'd4, 1'b1, 1'b1);
    send_frame(8'd3, 1'b1, 1'b0);
    send_frame(8'd3, 1'b1, 1'b1);
    send_frame(8'd4, 1'b1, 1'b1);
  endtask

  task automatic test_long_hold();
    write_reg(CFG_FIRST_DELAY, 16'd40);
    write_reg(CFG_REPEAT_PERIOD, 16'd7);
    repeat (60) send_frame(8'd200, 1'b1, 1'b1);
    // With a wide period only the first frame past the delay repeats.
    write_reg(CFG_FIRST_DELAY, 16'd60);
    write_reg(CFG_REPEAT_PERIOD, 16'd65434);
    repeat (3) send_frame(8'd200, 1'b1, 1'b1);
    send_frame(8'd200, 1'b0, 1'b1);
  endtask

  task automatic test_random_traffic();
    logic [CFG_W-1:0] delays [8];
    logic [CFG_W-1:0] periods [8];
    logic [KEY_W-1:0] pool [4];
    logic             down [4];
    int               left [4];
    int               k;
    int               r;
    delays = '{16'd0, 16'd3, 16'd5, 16'd1, 16'hFFFF, 16'd0, 16'd8, 16'd17};
    periods = '{16'd1, 16'd2, 16'd3, 16'hFFFF, 16'd5, 16'd0, 16'd6, 16'd4};
    for (int p = 0; p < 8; p++) begin
      write_reg(CFG_FIRST_DELAY, delays[p]);
      write_reg(CFG_REPEAT_PERIOD, periods[p]);
      gaps_on = $urandom_range(0, 3) != 0;
      stall_on = $urandom_range(0, 3) != 0;
      for (int j = 0; j < 4; j++) begin
        pool[j] = KEY_W'($urandom_range(0, 255));
        down[j] = 1'b0;
        left[j] = $urandom_range(0, 2);
      end
      for (int n = 0; n < 150; n++) begin
        if (p == 3 && n == 75) go_idle();
        r = $urandom_range(0, 99);
        if (r < 2) begin
          send_frame(KEY_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0);
        end else if (r < 12) begin
          send_frame(KEY_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
        end else begin
          k = $urandom_range(0, 3);
          if (left[k] == 0) begin
            down[k] = !down[k];
            if (!down[k]) left[k] = $urandom_range(0, 2);
            else if ($urandom_range(0, 4) == 0) left[k] = $urandom_range(20, 60);
            else left[k] = $urandom_range(1, 12);
          end else begin
            left[k]--;
          end
          send_frame(pool[k], down[k], 1'b1);
        end
      end
    end
  endtask

  initial begin : result_check
    key_report_t got;
    key_report_t want;
    logic        fire;
    int          stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      fire = out_valid && !out_stall;
      got = {out_key_echo, out_held, out_just_pressed, out_hold_frames, out_repeat_hit,
             out_any_held, out_any_just_pressed};
      @(posedge clk);
      if (fire) begin
        if (expected_reports.size() == 0) begin
          report_mismatch($sformatf("result for key %0d with no beat waiting",
                                    got.key_echo));
        end else begin
          want = expected_reports.pop_front();
          check_field("key_echo", 32'(got.key_echo), 32'(want.key_echo), want.key_echo);
          check_field("held", 32'(got.held), 32'(want.held), want.key_echo);
          check_field("just_pressed", 32'(got.just_pressed), 32'(want.just_pressed),
                      want.key_echo);
          check_field("hold_frames", 32'(got.hold_frames), 32'(want.hold_frames),
                      want.key_echo);
          check_field("repeat_hit", 32'(got.repeat_hit), 32'(want.repeat_hit),
                      want.key_echo);
          check_field("any_held", 32'(got.any_held), 32'(want.any_held), want.key_echo);
          check_field("any_just_pressed", 32'(got.any_just_pressed),
                      32'(want.any_just_pressed), want.key_echo);
        end
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else if (stall_on && $urandom_range(0, 99) < 25) begin
        out_stall <= 1'b1;
        stall_left = gap_len() - 1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(negedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) idle = 0;
      else idle++;
    end
    $display("** key_hold_counter_with_repeat: FAILED **");
    $finish;
  end

  initial begin
    foreach (hold_cnt[i]) hold_cnt[i] = '0;
    keys_held = '0;
    keys_just = '0;
    delay_reg = FIRST_DELAY_RST;
    period_reg = REPEAT_PERIOD_RST;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_typematic();
    test_zero_period();
    test_focus_loss();
    test_long_hold();
    test_random_traffic();
    go_idle();
    repeat (20) @(posedge clk);
    if (expected_reports.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_reports.size()));
    if (mismatches == 0) begin
      $display("** key_hold_counter_with_repeat: PASSED **");
    end else begin
      $display("** key_hold_counter_with_repeat: FAILED **");
    end
    $finish;
  end

endmodule
